// ===== hw/rtl/rac_pkg.sv =====
// Package for the rational accumulator ALU: payload structs, opcodes, status codes.
// Used by every module of the block; depends on nothing.
package rac_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int MAG_WIDTH = 66;

   localparam logic [2:0] OP_LOAD = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] operand_num;
      logic signed [31:0] operand_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_num;
      logic signed [31:0] result_den;
      logic [1:0]         status;
   } rsp_type;

   // Command and status between the sequencer and the shared reduce unit.
   typedef struct packed {
      logic start;
   } red_cmd_type;

   typedef struct packed {
      logic done;
      logic busy;
   } red_sts_type;

endpackage

// ===== hw/rtl/rational_accumulator_alu.sv =====
// Top level of the rational accumulator ALU: sequencer, accumulator, channels.
// Depends on rac_pkg and rac_reduce.
//
// Usage: a request transfer on req_ carries an opcode and an operand fraction.
// The block reduces the operand, forms the new fraction with exact 66-bit
// signed-magnitude products and sums, reduces it again and returns one
// response transfer on rsp_ with the accumulator after the step and a status.
// Only one request is in flight: req_stall is high from acceptance until the
// response has been taken. Latency depends on the passes through the shared
// gcd-and-divide unit. Each pass runs a binary gcd and then two restoring
// divisions. A load needs only the operand pass; the other opcodes make a
// second pass. Multiplications are single 33x33 steps, one per cycle.
// Reset (synchronous, active high) sets the accumulator to 0/1 and empties
// the response register. When the receiver stalls, the response holds steady
// and no new request is accepted until it is taken.
// Errors (zero denominator, divide by zero, overflow) leave the accumulator
// unchanged and report it with the matching status code.
module rational_accumulator_alu #(
   parameter int VALUE_WIDTH = rac_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rac_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rac_pkg::rsp_type rsp_data
);
   import rac_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RED1  = 4'd1;
   localparam logic [3:0] S_WAIT1 = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_MUL2  = 4'd4;
   localparam logic [3:0] S_MUL3  = 4'd5;
   localparam logic [3:0] S_SUM   = 4'd6;
   localparam logic [3:0] S_WAIT2 = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;
   localparam int MW = MAG_WIDTH;
   localparam logic [MW-1:0] LIM = MW'(1) << (VALUE_WIDTH - 1);

   logic [3:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic signed [VALUE_WIDTH-1:0] acc_num_ff, acc_num_in, acc_den_ff, acc_den_in;
   logic on_neg_ff, on_neg_in, od_neg_ff, od_neg_in;
   logic [MW-1:0] on_mag_ff, on_mag_in, od_mag_ff, od_mag_in;
   logic rn_neg_ff, rn_neg_in, rd_neg_ff, rd_neg_in;
   logic [MW-1:0] rn_mag_ff, rn_mag_in, rd_mag_ff, rd_mag_in, t_mag_ff, t_mag_in;
   logic t_neg_ff, t_neg_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic phase_ff, phase_in;

   red_cmd_type red_cmd;
   red_sts_type red_sts;
   logic [MW-1:0] red_a, red_b, red_qa, red_qb;

   logic signed [VALUE_WIDTH-1:0] in_num, in_den;
   logic an_neg, ad_neg;
   logic [MW-1:0] an_mag, ad_mag, in_num_mag, in_den_mag;
   logic [MW-1:0] mul_a, mul_b, mul_p;
   logic eq_den, oth_neg;
   logic [MW-1:0] sum_mag;
   logic sum_neg;
   logic fit_n, fit_d;

   assign in_num = req_data.operand_num[VALUE_WIDTH-1:0];
   assign in_den = req_data.operand_den[VALUE_WIDTH-1:0];
   assign in_num_mag = in_num[VALUE_WIDTH-1] ? MW'(-$signed({in_num[VALUE_WIDTH-1], in_num}))
                                             : MW'(in_num);
   assign in_den_mag = in_den[VALUE_WIDTH-1] ? MW'(-$signed({in_den[VALUE_WIDTH-1], in_den}))
                                             : MW'(in_den);
   assign an_neg = acc_num_ff[VALUE_WIDTH-1];
   assign ad_neg = acc_den_ff[VALUE_WIDTH-1];
   assign an_mag = an_neg ? MW'(-$signed({an_neg, acc_num_ff})) : MW'(acc_num_ff);
   assign ad_mag = ad_neg ? MW'(-$signed({ad_neg, acc_den_ff})) : MW'(acc_den_ff);

   // One shared 33x33 magnitude multiplier.
   assign mul_p = MW'(mul_a[32:0] * mul_b[32:0]);
   assign oth_neg = (op_ff == OP_SUB) ? (!on_neg_ff && on_mag_ff != '0) : on_neg_ff;
   assign eq_den = (ad_neg == od_neg_ff) && (ad_mag == od_mag_ff);

   always_comb begin
      mul_a = an_mag; mul_b = od_mag_ff;
      unique case (state_ff)
         S_MUL1: begin
            mul_a = an_mag;
            mul_b = (op_ff == OP_MUL) ? on_mag_ff : od_mag_ff;
         end
         S_MUL2: begin mul_a = on_mag_ff; mul_b = ad_mag; end
         S_MUL3: begin
            mul_a = ad_mag;
            mul_b = (op_ff == OP_DIV) ? on_mag_ff : od_mag_ff;
         end
         default: begin mul_a = an_mag; mul_b = od_mag_ff; end
      endcase
   end

   // Signed-magnitude add of rn (first term) and t (second term).
   always_comb begin
      if (rn_neg_ff == t_neg_ff) begin
         sum_mag = rn_mag_ff + t_mag_ff; sum_neg = rn_neg_ff;
      end else if (rn_mag_ff >= t_mag_ff) begin
         sum_mag = rn_mag_ff - t_mag_ff; sum_neg = rn_neg_ff;
      end else begin
         sum_mag = t_mag_ff - rn_mag_ff; sum_neg = t_neg_ff;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   // The second pass starts in the sum state, so it takes the sum directly.
   assign red_cmd.start = (state_ff == S_RED1) ||
                          (state_ff == S_SUM && op_ff != OP_LOAD && !phase_ff);
   assign red_a = (state_ff == S_RED1) ? on_mag_ff : sum_mag;
   assign red_b = (state_ff == S_RED1) ? od_mag_ff : rd_mag_ff;

   assign fit_n = rn_neg_ff ? (red_qa <= LIM) : (red_qa < LIM);
   assign fit_d = rd_neg_ff ? (red_qb <= LIM) : (red_qb < LIM);

   always_comb begin
      state_in = state_ff; op_in = op_ff;
      acc_num_in = acc_num_ff; acc_den_in = acc_den_ff;
      on_neg_in = on_neg_ff; on_mag_in = on_mag_ff;
      od_neg_in = od_neg_ff; od_mag_in = od_mag_ff;
      rn_neg_in = rn_neg_ff; rn_mag_in = rn_mag_ff;
      rd_neg_in = rd_neg_ff; rd_mag_in = rd_mag_ff;
      t_neg_in = t_neg_ff; t_mag_in = t_mag_ff;
      status_in = status_ff; rsp_valid_in = rsp_valid_ff; phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_data.opcode;
               on_neg_in = in_num[VALUE_WIDTH-1]; on_mag_in = in_num_mag;
               od_neg_in = in_den[VALUE_WIDTH-1]; od_mag_in = in_den_mag;
               status_in = ST_OK;
               if (req_data.opcode > OP_DIV) begin
                  state_in = S_RESP; rsp_valid_in = 1'b1;
               end else if (in_den_mag == '0) begin
                  status_in = ST_ZERO_DEN; state_in = S_RESP; rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_RED1;
               end
            end
         end
         S_RED1: state_in = S_WAIT1;
         S_WAIT1: begin
            if (red_sts.done) begin
               on_mag_in = red_qa; od_mag_in = red_qb;
               if (red_qa == '0) on_neg_in = 1'b0;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            // Forms rn = an*od (or an*on for multiply), or the simple cases.
            if (op_ff == OP_LOAD) begin
               rn_neg_in = on_neg_ff; rn_mag_in = on_mag_ff;
               rd_neg_in = od_neg_ff; rd_mag_in = od_mag_ff;
               state_in = S_SUM;
            end else if (op_ff == OP_DIV && on_mag_ff == '0) begin
               status_in = ST_ZERO_DEN; state_in = S_RESP; rsp_valid_in = 1'b1;
            end else if ((op_ff == OP_ADD || op_ff == OP_SUB) && eq_den) begin
               rn_neg_in = an_neg; rn_mag_in = an_mag;
               t_neg_in = oth_neg; t_mag_in = on_mag_ff;
               rd_neg_in = ad_neg; rd_mag_in = ad_mag;
               state_in = S_SUM;
            end else begin
               rn_mag_in = mul_p;
               rn_neg_in = (an_neg != ((op_ff == OP_MUL) ? on_neg_ff : od_neg_ff))
                           && mul_p != '0;
               t_mag_in = '0; t_neg_in = 1'b0;
               state_in = (op_ff == OP_ADD || op_ff == OP_SUB) ? S_MUL2 : S_MUL3;
            end
         end
         S_MUL2: begin
            t_mag_in = mul_p;
            t_neg_in = (oth_neg != ad_neg) && mul_p != '0;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            rd_mag_in = mul_p;
            rd_neg_in = (ad_neg != ((op_ff == OP_DIV) ? on_neg_ff : od_neg_ff))
                        && mul_p != '0;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (op_ff != OP_LOAD && !phase_ff) begin
               rn_mag_in = sum_mag; rn_neg_in = sum_neg;
            end
            state_in = S_WAIT2; phase_in = 1'b0;
         end
         S_WAIT2: begin
            // Load is already reduced; others run the second reduce pass.
            if (op_ff == OP_LOAD || red_sts.done) begin
               if (op_ff == OP_LOAD) begin
                  if (VALUE_WIDTH == 32 || (rn_neg_ff ? rn_mag_ff <= LIM : rn_mag_ff < LIM)
                      && (rd_neg_ff ? rd_mag_ff <= LIM : rd_mag_ff < LIM)) begin
                     acc_num_in = rn_neg_ff ? VALUE_WIDTH'(-rn_mag_ff)
                                            : VALUE_WIDTH'(rn_mag_ff);
                     acc_den_in = rd_neg_ff ? VALUE_WIDTH'(-rd_mag_ff)
                                            : VALUE_WIDTH'(rd_mag_ff);
                  end else begin
                     status_in = ST_OVERFLOW;
                  end
               end else if (fit_n && fit_d) begin
                  acc_num_in = (rn_neg_ff && red_qa != '0) ? VALUE_WIDTH'(-red_qa)
                                                          : VALUE_WIDTH'(red_qa);
                  acc_den_in = rd_neg_ff ? VALUE_WIDTH'(-red_qb) : VALUE_WIDTH'(red_qb);
               end else begin
                  status_in = ST_OVERFLOW;
               end
               state_in = S_RESP; rsp_valid_in = 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_num_ff <= '0;
         acc_den_ff <= VALUE_WIDTH'(1);
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_num_ff <= acc_num_in;
         acc_den_ff <= acc_den_in;
         phase_ff <= phase_in;
      end
      op_ff <= op_in; status_ff <= status_in;
      on_neg_ff <= on_neg_in; on_mag_ff <= on_mag_in;
      od_neg_ff <= od_neg_in; od_mag_ff <= od_mag_in;
      rn_neg_ff <= rn_neg_in; rn_mag_ff <= rn_mag_in;
      rd_neg_ff <= rd_neg_in; rd_mag_ff <= rd_mag_in;
      t_neg_ff <= t_neg_in; t_mag_ff <= t_mag_in;
   end

   rac_reduce u_reduce (
      .clock (clock), .reset (reset), .cmd (red_cmd),
      .a_in (red_a), .b_in (red_b), .sts (red_sts),
      .a_out (red_qa), .b_out (red_qb)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.result_num = 32'(acc_num_ff);
   assign rsp_data.result_den = 32'(acc_den_ff);
   assign rsp_data.status = status_ff;

   // A response is only offered in the response state.
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_RESP) else $error("response outside response state");
   // The accumulator never changes while a response waits.
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> $stable(acc_num_ff) && $stable(acc_den_ff))
      else $error("accumulator changed during response");
   // The denominator is never zero.
   a_den_nz: assert property (@(posedge clock) disable iff (reset)
      acc_den_ff != '0) else $error("zero denominator stored");
endmodule

// ===== hw/rtl/rac_reduce.sv =====
// Shared reduce unit: binary gcd of two magnitudes, then divides both by it
// with a restoring one-bit-per-cycle divider. Depends on rac_pkg.
module rac_reduce (
   input  logic                          clock,
   input  logic                          reset,
   input  rac_pkg::red_cmd_type          cmd,
   input  logic [rac_pkg::MAG_WIDTH-1:0] a_in,
   input  logic [rac_pkg::MAG_WIDTH-1:0] b_in,
   output rac_pkg::red_sts_type          sts,
   output logic [rac_pkg::MAG_WIDTH-1:0] a_out,
   output logic [rac_pkg::MAG_WIDTH-1:0] b_out
);
   import rac_pkg::*;

   localparam logic [2:0] R_IDLE = 3'd0;
   localparam logic [2:0] R_GCD  = 3'd1;
   localparam logic [2:0] R_DIVA = 3'd2;
   localparam logic [2:0] R_DIVB = 3'd3;
   localparam logic [2:0] R_DONE = 3'd4;
   localparam int CW = $clog2(MAG_WIDTH + 1);

   logic [2:0] state_ff, state_in;
   logic [MAG_WIDTH-1:0] u_ff, u_in, v_ff, v_in, a_ff, a_in_r, b_ff, b_in_r;
   logic [MAG_WIDTH-1:0] g_ff, g_in, q_ff, q_in;
   logic [MAG_WIDTH:0]   rem_ff, rem_in;
   logic [CW-1:0] shf_ff, shf_in, cnt_ff, cnt_in;
   logic [MAG_WIDTH:0] trial;
   logic [MAG_WIDTH-1:0] diff;

   assign trial = {rem_ff[MAG_WIDTH-1:0],
                   (state_ff == R_DIVA) ? a_ff[MAG_WIDTH-1] : b_ff[MAG_WIDTH-1]};
   assign diff  = (u_ff > v_ff) ? (u_ff - v_ff) : (v_ff - u_ff);

   always_comb begin
      state_in = state_ff;
      u_in = u_ff; v_in = v_ff; a_in_r = a_ff; b_in_r = b_ff;
      g_in = g_ff; q_in = q_ff; rem_in = rem_ff; shf_in = shf_ff; cnt_in = cnt_ff;
      unique case (state_ff)
         R_IDLE: begin
            if (cmd.start) begin
               u_in = a_in; v_in = b_in; a_in_r = a_in; b_in_r = b_in;
               shf_in = '0;
               state_in = R_GCD;
            end
         end
         R_GCD: begin
            // Binary gcd, one step per cycle.
            if (u_ff == '0 || v_ff == '0 || u_ff == v_ff) begin
               g_in = ((u_ff == '0) ? v_ff : u_ff) << shf_ff;
               rem_in = '0; q_in = '0; cnt_in = CW'(MAG_WIDTH);
               state_in = ((u_ff | v_ff) == '0) ? R_DONE : R_DIVA;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1; v_in = v_ff >> 1; shf_in = shf_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else begin
               u_in = (u_ff < v_ff) ? u_ff : v_ff;
               v_in = diff >> 1;
            end
         end
         R_DIVA, R_DIVB: begin
            if (trial >= {1'b0, g_ff}) begin
               rem_in = trial - {1'b0, g_ff};
               q_in = {q_ff[MAG_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in = {q_ff[MAG_WIDTH-2:0], 1'b0};
            end
            if (state_ff == R_DIVA) a_in_r = a_ff << 1;
            else b_in_r = b_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               if (state_ff == R_DIVA) begin
                  u_in = q_in; rem_in = '0; cnt_in = CW'(MAG_WIDTH);
                  state_in = R_DIVB;
               end else begin
                  v_in = q_in;
                  state_in = R_DONE;
               end
            end
         end
         R_DONE: state_in = R_IDLE;
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= R_IDLE;
      else state_ff <= state_in;
      u_ff <= u_in; v_ff <= v_in; a_ff <= a_in_r; b_ff <= b_in_r;
      g_ff <= g_in; q_ff <= q_in; rem_ff <= rem_in; shf_ff <= shf_in; cnt_ff <= cnt_in;
   end

   // With a zero gcd both inputs were zero; u/v then still hold zeros.
   assign sts.done = (state_ff == R_DONE);
   assign sts.busy = (state_ff != R_IDLE);
   assign a_out = u_ff;
   assign b_out = v_ff;
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the rational accumulator ALU: random and directed opcode/fraction
// transfers checked against an in-bench fraction predictor. Depends on rac_pkg.
module tb_top;
   import rac_pkg::*;

   // The predictor keeps its own accumulator and works in signed magnitude, as the
   // block does. Magnitudes stay below 2**64 since every operand part is 32 bits.
   class fraction_scoreboard;
      logic signed [63:0] num_q;
      logic signed [63:0] den_q;
      rsp_type            pending[$];
      int                 errors;
      int                 checked;

      function new();
         num_q   = 0;
         den_q   = 1;
         errors  = 0;
         checked = 0;
      endfunction

      function logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
         logic [63:0] t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      // Sum of two signed-magnitude values; a zero sum carries no sign.
      function void sum_mag(bit an, logic [63:0] am, bit bn, logic [63:0] bm,
                            output bit rn, output logic [63:0] rm);
         if (an == bn) begin
            rm = am + bm;
            rn = an;
         end else if (am >= bm) begin
            rm = am - bm;
            rn = an;
         end else begin
            rm = bm - am;
            rn = bn;
         end
         if (rm == 0) rn = 0;
      endfunction

      function bit fits32(bit n, logic [63:0] m);
         return n ? (m <= 64'h8000_0000) : (m < 64'h8000_0000);
      endfunction

      function void note_request(req_type r);
         bit          on_neg, od_neg, an_neg, ad_neg, rn_neg, rd_neg, t_neg;
         logic [63:0] on_mag, od_mag, an_mag, ad_mag, rn_mag, rd_mag, t_mag, g;
         logic [63:0] sn, sd;
         logic [1:0]  st;
         bit          apply;
         rsp_type     e;
         sn = r.operand_num;
         sd = r.operand_den;
         on_neg = sn[63];
         on_mag = on_neg ? -sn : sn;
         od_neg = sd[63];
         od_mag = od_neg ? -sd : sd;
         an_neg = num_q < 0;
         an_mag = an_neg ? -num_q : num_q;
         ad_neg = den_q < 0;
         ad_mag = ad_neg ? -den_q : den_q;
         st = ST_OK;
         apply = 1;
         if (r.opcode > OP_DIV) begin
            apply = 0;
         end else if (od_mag == 0) begin
            st = ST_ZERO_DEN;
            apply = 0;
         end else begin
            g = gcd_of(on_mag, od_mag);
            on_mag = on_mag / g;
            od_mag = od_mag / g;
            if (on_mag == 0) on_neg = 0;
            case (r.opcode)
               OP_LOAD: begin
                  rn_neg = on_neg; rn_mag = on_mag;
                  rd_neg = od_neg; rd_mag = od_mag;
               end
               OP_ADD, OP_SUB: begin
                  t_neg = (r.opcode == OP_SUB && on_mag != 0) ? !on_neg : on_neg;
                  if (ad_neg == od_neg && ad_mag == od_mag) begin
                     sum_mag(an_neg, an_mag, t_neg, on_mag, rn_neg, rn_mag);
                     rd_neg = ad_neg; rd_mag = ad_mag;
                  end else begin
                     sum_mag(an_neg != od_neg && an_mag != 0, an_mag * od_mag,
                             t_neg != ad_neg && on_mag != 0, on_mag * ad_mag,
                             rn_neg, rn_mag);
                     rd_mag = ad_mag * od_mag;
                     rd_neg = ad_neg != od_neg;
                  end
               end
               OP_MUL: begin
                  rn_mag = an_mag * on_mag;
                  rn_neg = an_neg != on_neg && rn_mag != 0;
                  rd_mag = ad_mag * od_mag;
                  rd_neg = ad_neg != od_neg;
               end
               default: begin
                  if (on_mag == 0) begin
                     st = ST_ZERO_DEN;
                     apply = 0;
                  end
                  rn_mag = an_mag * od_mag;
                  rn_neg = an_neg != od_neg && rn_mag != 0;
                  rd_mag = ad_mag * on_mag;
                  rd_neg = ad_neg != on_neg && rd_mag != 0;
               end
            endcase
            if (apply) begin
               g = gcd_of(rn_mag, rd_mag);
               if (g != 0) begin
                  rn_mag = rn_mag / g;
                  rd_mag = rd_mag / g;
               end
               if (rn_mag == 0) rn_neg = 0;
               if (!fits32(rn_neg, rn_mag) || !fits32(rd_neg, rd_mag)) begin
                  st = ST_OVERFLOW;
                  apply = 0;
               end
            end
         end
         if (apply) begin
            num_q = rn_neg ? -$signed(rn_mag) : $signed(rn_mag);
            den_q = rd_neg ? -$signed(rd_mag) : $signed(rd_mag);
         end
         e.result_num = num_q[31:0];
         e.result_den = den_q[31:0];
         e.status     = st;
         pending.push_back(e);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("MISMATCH unexpected response %p at %0t", got, $realtime);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.result_num !== e.result_num) report("result_num", got.result_num, e.result_num);
         if (got.result_den !== e.result_den) report("result_den", got.result_den, e.result_den);
         if (got.status !== e.status) report("status", got.status, e.status);
      endtask
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   fraction_scoreboard fractions = new();
   int  hold_off_cycles = 0;   // when nonzero, the receiver stalls for that many cycles
   int  status_seen[4];
   bit  stimulus_done = 0;

   rational_accumulator_alu i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Offers one request after a random gap and holds it until the transfer happens.
   // Valid stays high into the next request when there is no gap; idle_sender drops it.
   task send_request(logic [2:0] op, logic [31:0] n, logic [31:0] d);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_data  <= '{opcode: op, operand_num: n, operand_den: d};
      do @(posedge clock); while (req_stall);
      fractions.note_request(req_data);
   endtask

   // Drops valid after the last request of a burst.
   task idle_sender();
      @(negedge clock);
      req_valid <= 0;
   endtask

   // Small values keep the accumulator in range; a few raw 32-bit values reach overflow
   // and the bit extremes.
   function logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
         2:       return 0;
         3, 4:    return $urandom_range(0, 1) ? 32'd1 : -32'sd1;
         default: return $signed($urandom_range(0, 60)) - 30;
      endcase
   endfunction

   // Receiver: samples at the rising edge and sets stall at the falling edge.
   initial begin
      int wait_cycles;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
         if (wait_cycles > 0) begin
            rsp_stall <= 1;
            repeat (wait_cycles - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_data.status]++;
         fractions.check_response(rsp_data);
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: each opcode, zero denominators, divide by zero, overflow, sign cases.
      send_request(OP_ADD, 1, 2);
      send_request(OP_ADD, 1, 2);
      send_request(OP_SUB, 3, -4);
      send_request(OP_MUL, -6, 8);
      send_request(OP_DIV, 2, -3);
      send_request(OP_DIV, 0, 5);
      send_request(OP_LOAD, 7, 0);
      send_request(OP_ADD, 7, 0);
      send_request(OP_MUL, 0, 0);
      send_request(OP_DIV, 1, 0);
      send_request(OP_SUB, 9, 0);
      send_request(OP_LOAD, 32'h7fff_ffff, 1);
      send_request(OP_ADD, 1, 1);
      send_request(OP_MUL, 32'h7fff_ffff, 32'h7fff_fffe);
      send_request(OP_LOAD, 32'h8000_0000, 32'h8000_0000);
      send_request(OP_LOAD, 32'h8000_0000, 32'h7fff_ffff);
      send_request(OP_DIV, -1, 1);
      send_request(OP_LOAD, 0, -5);
      send_request(OP_SUB, 0, 7);
      send_request(3'd5, 1, 1);
      send_request(3'd7, 32'hffff_ffff, 0);
      send_request(OP_LOAD, 4, -6);
      send_request(OP_ADD, 1, -3);

      // Long receiver hold-off while requests keep coming, then a sender pause
      // until every response is back.
      hold_off_cycles = 1500;
      repeat (4) send_request(OP_ADD, pick_value(), $signed($urandom_range(1, 9)));
      idle_sender();
      wait (fractions.pending.size() == 0);

      repeat (1830) begin
         if ($urandom_range(0, 30) == 0)
            send_request(3'($urandom_range(5, 7)), $urandom(), $urandom());
         else if ($urandom_range(0, 12) == 0) send_request(OP_LOAD, pick_value(), pick_value());
         else send_request(3'($urandom_range(0, 4)), pick_value(), pick_value());
      end
      idle_sender();

      fork
         wait (fractions.pending.size() == 0);
         repeat (5_000_000) @(posedge clock);
      join_any
      repeat (500) @(posedge clock);
      $display("Covered %0d responses: %0d ok, %0d zero-denominator/divide-by-zero, %0d overflow.",
               fractions.checked, status_seen[0], status_seen[1], status_seen[2]);
      if (fractions.pending.size() != 0) begin
         $display("MISMATCH %0d responses never arrived", fractions.pending.size());
         fractions.errors++;
      end
      if (fractions.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: stops the run if the responses never finish.
   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/rac_pkg.sv
hw/rtl/rac_reduce.sv
hw/rtl/rational_accumulator_alu.sv
dv/tb_top.sv
